// ===== hw/rtl/cfd_pkg.sv =====
// Shared types and constants for the complex decimating FIR unit.
// Holds the sequencer state type, register indexes and field widths.
// No dependencies.
`default_nettype none

package cfd_pkg;

    // Field widths fixed by the register map and the item format
    localparam int AT_W       = 7;
    localparam int DEC_W      = 9;
    localparam int PHASE_W    = 8;
    localparam int TAP_IDX_W  = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    // Largest decimation factor honored
    localparam logic [DEC_W-1:0] DEC_MAX = 9'd256;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_TAPS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECIMATION  = 2'd1;

    // Item modes
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_TAP    = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_FINISH
    } cfd_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/complex_fir_decimator_unit.sv =====
// Complex decimating FIR filter built around one shared complex multiply-accumulate.
// Holds the sequencer, coefficient and history memories and output register.
// Depends on cfd_pkg.
`default_nettype none

// Usage
//   Input channel (in_valid / in_stall): one transaction per item. mode selects a
//   coefficient write (tap_index, tap_re, tap_im) or a sample push (sample_re,
//   sample_im). A coefficient write also clears the history, write pointer and
//   decimation phase. Output channel (out_valid / out_stall) carries out_re,
//   out_im and clipped, one transaction per decimated filter output.
//   Config port (cfg_we, cfg_index, cfg_data): index 0 is active_taps, index 1 is
//   decimation; write only while the unit is idle. Writing active_taps also
//   clears the history.
// Sequence
//   A coefficient write or a sample push that does not complete a decimation
//   period completes in its accepting cycle. A push that completes it runs the
//   accepting cycle, a pass in which the shared complex multiply-accumulate
//   walks the len effective taps one at a time, a drain (memory read, product
//   register, accumulate) and a round/saturate step. in_stall stays high until
//   that step loads the output register, which raises out_valid.
// Reset
//   After rst_n releases, a clearing pass zeroes every coefficient memory entry
//   with in_stall high; config writes are still taken.
// Backpressure
//   While a result waits under out_stall, new items are still accepted; a
//   finished sum holds in the round/saturate step until the output register frees.

module complex_fir_decimator_unit
    import cfd_pkg::*;
#(
    parameter int MAX_TAPS  = 64,
    parameter int DATA_BITS = 16
)
(
    input  wire                        clk,
    input  wire                        rst_n,

    input  wire                        in_valid,
    output logic                       in_stall,
    input  wire                        mode,
    input  wire  [TAP_IDX_W-1:0]       tap_index,
    input  wire  signed [DATA_BITS-1:0] tap_re,
    input  wire  signed [DATA_BITS-1:0] tap_im,
    input  wire  signed [DATA_BITS-1:0] sample_re,
    input  wire  signed [DATA_BITS-1:0] sample_im,

    output logic                       out_valid,
    input  wire                        out_stall,
    output logic signed [DATA_BITS-1:0] out_re,
    output logic signed [DATA_BITS-1:0] out_im,
    output logic                       clipped,

    input  wire                        cfg_we,
    input  wire  [CFG_IDX_W-1:0]       cfg_index,
    input  wire  [CFG_DATA_W-1:0]      cfg_data
);

    localparam int AW     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int LEN_W  = $clog2(MAX_TAPS + 1);
    localparam int PW     = 2 * DATA_BITS;
    localparam int ACC_FULL = 2 * DATA_BITS + 1 + $clog2(MAX_TAPS);
    localparam int ACC_W  = (ACC_FULL > 64) ? 64 : ACC_FULL;
    localparam int SH_W   = ACC_W - DATA_BITS + 1;
    localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) <<< (DATA_BITS - 2);
    localparam logic [DATA_BITS-1:0] SAT_MAX = {1'b0, {(DATA_BITS-1){1'b1}}};
    localparam logic [DATA_BITS-1:0] SAT_MIN = {1'b1, {(DATA_BITS-1){1'b0}}};

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    cfd_state_t           state_reg, state_next;
    logic [AW-1:0]        clr_cnt_reg, clr_cnt_next;
    logic [AT_W-1:0]      active_taps_reg, active_taps_next;
    logic [DEC_W-1:0]     decimation_reg, decimation_next;
    logic [AW-1:0]        wp_reg, wp_next;
    logic [LEN_W-1:0]     fill_reg, fill_next;
    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic [AW-1:0]        k_reg, k_next;
    logic [AW-1:0]        pos_reg, pos_next;
    logic                 v1_reg, h1_reg, v2_reg;
    logic                 out_valid_reg, out_valid_next;

    logic signed [DATA_BITS-1:0] coef_rd_re_reg, coef_rd_im_reg;
    logic signed [DATA_BITS-1:0] hist_rd_re_reg, hist_rd_im_reg;
    logic signed [PW-1:0]        prod_rr_reg, prod_ii_reg, prod_ri_reg, prod_ir_reg;
    logic signed [ACC_W-1:0]     acc_re_reg, acc_im_reg;
    logic signed [DATA_BITS-1:0] out_re_reg, out_im_reg;
    logic                        clipped_reg;

    // Memories
    logic signed [DATA_BITS-1:0] coef_re_mem [MAX_TAPS];
    logic signed [DATA_BITS-1:0] coef_im_mem [MAX_TAPS];
    logic signed [DATA_BITS-1:0] hist_re_mem [MAX_TAPS];
    logic signed [DATA_BITS-1:0] hist_im_mem [MAX_TAPS];

    // ------------------------------------------------------------------
    // Combinational control
    // ------------------------------------------------------------------
    logic                  in_accept;
    logic                  out_take;
    logic [31:0]           at_ext;
    logic [LEN_W-1:0]      len;
    logic [AW-1:0]         len_m1;
    logic [DEC_W-1:0]      dec_eff;
    logic [PHASE_W-1:0]    phase_inc;
    logic                  emit;
    logic                  issue;
    logic                  hist_hit;
    logic                  acc_clr;
    logic                  load_out;

    logic                        coef_we;
    logic [AW-1:0]               coef_waddr;
    logic signed [DATA_BITS-1:0] coef_wre, coef_wim;
    logic                        hist_we;

    logic signed [DATA_BITS-1:0] x_re, x_im;
    logic [DATA_BITS:0]          fin_re, fin_im;

    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);

    // Effective tap count: zero acts as one, clamp to MAX_TAPS
    always_comb
    begin
        at_ext = 32'(active_taps_reg);
        if (active_taps_reg == '0)
        begin
            len = LEN_W'(1);
        end
        else if (at_ext > 32'(MAX_TAPS))
        begin
            len = LEN_W'(MAX_TAPS);
        end
        else
        begin
            len = at_ext[LEN_W-1:0];
        end
        len_m1 = AW'(32'(len) - 32'd1);
    end

    // Effective decimation: zero acts as one, clamp to DEC_MAX
    always_comb
    begin
        if (decimation_reg == '0)
        begin
            dec_eff = DEC_W'(1);
        end
        else if (decimation_reg > DEC_MAX)
        begin
            dec_eff = DEC_MAX;
        end
        else
        begin
            dec_eff = decimation_reg;
        end
    end

    assign phase_inc = phase_reg + PHASE_W'(1);
    assign emit      = (phase_inc == '0) || ({1'b0, phase_inc} >= dec_eff);
    assign hist_hit  = (32'(pos_reg) < 32'(fill_reg));

    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        active_taps_next = active_taps_reg;
        decimation_next  = decimation_reg;
        wp_next          = wp_reg;
        fill_next        = fill_reg;
        phase_next       = phase_reg;
        k_next           = k_reg;
        pos_next         = pos_reg;
        issue            = 1'b0;
        acc_clr          = 1'b0;
        load_out         = 1'b0;
        coef_we          = 1'b0;
        coef_waddr       = clr_cnt_reg;
        coef_wre         = '0;
        coef_wim         = '0;
        hist_we          = 1'b0;

        // Config writes land in any state; the history clear rides with active_taps
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_ACTIVE_TAPS:
                begin
                    active_taps_next = cfg_data[AT_W-1:0];
                    wp_next          = '0;
                    fill_next        = '0;
                    phase_next       = '0;
                end
                CFG_DECIMATION:
                begin
                    decimation_next = cfg_data[DEC_W-1:0];
                end
                default:
                begin
                end
            endcase
        end

        case (state_reg)
            ST_CLEAR:
            begin
                // Zero one coefficient per cycle after reset
                coef_we = 1'b1;
                if (32'(clr_cnt_reg) + 32'd1 == 32'(MAX_TAPS))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + AW'(1);
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (mode == MODE_TAP)
                    begin
                        // Drop an index past the memory, clear history anyway
                        if (32'(tap_index) < 32'(MAX_TAPS))
                        begin
                            coef_we    = 1'b1;
                            coef_waddr = AW'(tap_index);
                            coef_wre   = tap_re;
                            coef_wim   = tap_im;
                        end
                        wp_next    = '0;
                        fill_next  = '0;
                        phase_next = '0;
                    end
                    else
                    begin
                        hist_we = 1'b1;
                        if (32'(wp_reg) + 32'd1 >= 32'(len))
                        begin
                            wp_next = '0;
                        end
                        else
                        begin
                            wp_next = wp_reg + AW'(1);
                        end
                        if (fill_reg != len)
                        begin
                            fill_next = fill_reg + LEN_W'(1);
                        end
                        if (emit)
                        begin
                            phase_next = '0;
                            pos_next   = wp_reg;
                            k_next     = '0;
                            acc_clr    = 1'b1;
                            state_next = ST_MAC;
                        end
                        else
                        begin
                            phase_next = phase_inc;
                        end
                    end
                end
            end
            ST_MAC:
            begin
                // Issue one tap per cycle, walking the history backward
                issue  = 1'b1;
                k_next = k_reg + AW'(1);
                if (pos_reg == '0)
                begin
                    pos_next = len_m1;
                end
                else
                begin
                    pos_next = pos_reg - AW'(1);
                end
                if (32'(k_reg) + 32'd1 == 32'(len))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // Hold the sum until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            active_taps_reg <= AT_W'(1);
            decimation_reg  <= DEC_W'(1);
            wp_reg          <= '0;
            fill_reg        <= '0;
            phase_reg       <= '0;
            k_reg           <= '0;
            pos_reg         <= '0;
            v1_reg          <= 1'b0;
            h1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_cnt_reg     <= clr_cnt_next;
            active_taps_reg <= active_taps_next;
            decimation_reg  <= decimation_next;
            wp_reg          <= wp_next;
            fill_reg        <= fill_next;
            phase_reg       <= phase_next;
            k_reg           <= k_next;
            pos_reg         <= pos_next;
            v1_reg          <= issue;
            h1_reg          <= issue && hist_hit;
            v2_reg          <= v1_reg;
            out_valid_reg   <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Memories: one write and one registered read each
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_re_mem[coef_waddr] <= coef_wre;
            coef_im_mem[coef_waddr] <= coef_wim;
        end
        coef_rd_re_reg <= coef_re_mem[k_reg];
        coef_rd_im_reg <= coef_im_mem[k_reg];
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_re_mem[wp_reg] <= sample_re;
            hist_im_mem[wp_reg] <= sample_im;
        end
        hist_rd_re_reg <= hist_re_mem[pos_reg];
        hist_rd_im_reg <= hist_im_mem[pos_reg];
    end

    // ------------------------------------------------------------------
    // Shared complex multiply-accumulate
    // ------------------------------------------------------------------
    // History slots not written since the last clear read as zero
    assign x_re = h1_reg ? hist_rd_re_reg : '0;
    assign x_im = h1_reg ? hist_rd_im_reg : '0;

    always_ff @(posedge clk)
    begin
        prod_rr_reg <= PW'(coef_rd_re_reg) * PW'(x_re);
        prod_ii_reg <= PW'(coef_rd_im_reg) * PW'(x_im);
        prod_ri_reg <= PW'(coef_rd_re_reg) * PW'(x_im);
        prod_ir_reg <= PW'(coef_rd_im_reg) * PW'(x_re);

        if (acc_clr)
        begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_re_reg <= acc_re_reg + ACC_W'(prod_rr_reg) - ACC_W'(prod_ii_reg);
            acc_im_reg <= acc_im_reg + ACC_W'(prod_ri_reg) + ACC_W'(prod_ir_reg);
        end
    end

    // ------------------------------------------------------------------
    // Round, shift and saturate; result is {clip, value}
    // ------------------------------------------------------------------
    function automatic logic [DATA_BITS:0] finish_part(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0]  r;
        logic [SH_W-1:0]          s;
        logic [SH_W-DATA_BITS:0]  top;
        logic [DATA_BITS:0]       res;
        r   = acc + RND;
        s   = r[ACC_W-1:DATA_BITS-1];
        top = s[SH_W-1:DATA_BITS-1];
        if ((&top) || !(|top))
        begin
            res = {1'b0, s[DATA_BITS-1:0]};
        end
        else if (s[SH_W-1])
        begin
            res = {1'b1, SAT_MIN};
        end
        else
        begin
            res = {1'b1, SAT_MAX};
        end
        return res;
    endfunction

    assign fin_re = finish_part(acc_re_reg);
    assign fin_im = finish_part(acc_im_reg);

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_re_reg  <= fin_re[DATA_BITS-1:0];
            out_im_reg  <= fin_im[DATA_BITS-1:0];
            clipped_reg <= fin_re[DATA_BITS] | fin_im[DATA_BITS];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_re    = out_re_reg;
    assign out_im    = out_im_reg;
    assign clipped   = clipped_reg;

`ifndef SYNTHESIS
    // History fill never passes the tap count in use
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= 32'(len))
        else $error("history fill count exceeds tap count");

    // Write pointer stays inside the active history
    a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(wp_reg) < 32'(len))
        else $error("write pointer outside active history");

    // Products only flow while a sum is being built
    a_pipe_scope: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg || v2_reg) |-> (state_reg == ST_MAC || state_reg == ST_DRAIN))
        else $error("multiply pipeline active outside accumulation");

    // The finishing step sees a fully drained accumulator
    a_finish_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |-> (!v1_reg && !v2_reg && !issue))
        else $error("round/saturate step reached with products in flight");
`endif

endmodule

`default_nettype wire
